// ===== hw/rtl/yuyv422_to_rgb888_converter_defines.svh =====
// assertion macros for the yuyv to rgb converter
// no dependencies; included by files that carry concurrent checks
`ifndef YUYV422_TO_RGB888_CONVERTER_DEFINES_SVH
`define YUYV422_TO_RGB888_CONVERTER_DEFINES_SVH
`ifndef SYNTHESIS
`define Y2R_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("y2r check failed");
`define Y2R_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("y2r check failed");
`else
`define Y2R_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define Y2R_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/y2r_pkg.sv =====
// widths, fixed-point coefficients and shared types of the yuyv to rgb converter
// no dependencies
`default_nettype none

package y2r_pkg;

	localparam int PIX_W    = 8;
	localparam int FRAC_W   = 16;
	localparam int COEF_W   = 17;
	// signed coefficient times signed centered chroma
	localparam int PROD_W   = (COEF_W + 1) + (PIX_W + 1);
	localparam int SUM_W    = PROD_W + 1;

	// unsigned q16 coefficients
	localparam logic [COEF_W-1:0] COEF_V_TO_R = 17'd89831;
	localparam logic [COEF_W-1:0] COEF_V_TO_G = 17'd45744;
	localparam logic [COEF_W-1:0] COEF_U_TO_G = 17'd22127;
	localparam logic [COEF_W-1:0] COEF_U_TO_B = 17'd113538;

	localparam logic [PIX_W:0]   CHROMA_ZERO = 9'd128;
	localparam logic [PIX_W-1:0] CHAN_MAX    = 8'd255;
	localparam logic [PIX_W-1:0] SCALE_NUM   = 8'd220;
	localparam logic [PIX_W-1:0] SCALE_MAX   = 8'd219;
	localparam int               SCALE_SHIFT = 8;

	typedef struct packed {
		logic signed [PROD_W-1:0] vr;
		logic signed [PROD_W-1:0] vg;
		logic signed [PROD_W-1:0] ug;
		logic signed [PROD_W-1:0] ub;
	} chroma_prod_t;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} rgb_t;

endpackage

`default_nettype wire

// ===== hw/rtl/y2r_ifs.sv =====
// stream interfaces: yuyv macropixel in, rgb pixel pair out
// depends on y2r_pkg
`default_nettype none

interface yuyv_if;
	import y2r_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] luma_first;
	logic [PIX_W-1:0] chroma_blue;
	logic [PIX_W-1:0] luma_second;
	logic [PIX_W-1:0] chroma_red;
	logic             frame_end_in;

	modport source (
		output valid, luma_first, chroma_blue, luma_second, chroma_red, frame_end_in,
		input  ready
	);
	modport sink (
		input  valid, luma_first, chroma_blue, luma_second, chroma_red, frame_end_in,
		output ready
	);
endinterface

interface rgb_if;
	import y2r_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] red_first;
	logic [PIX_W-1:0] green_first;
	logic [PIX_W-1:0] blue_first;
	logic [PIX_W-1:0] red_second;
	logic [PIX_W-1:0] green_second;
	logic [PIX_W-1:0] blue_second;
	logic             frame_end_out;

	modport source (
		output valid, red_first, green_first, blue_first,
		       red_second, green_second, blue_second, frame_end_out,
		input  ready
	);
	modport sink (
		input  valid, red_first, green_first, blue_first,
		       red_second, green_second, blue_second, frame_end_out,
		output ready
	);
endinterface

`default_nettype wire

// ===== hw/rtl/y2r_chroma.sv =====
// shared chroma products: centers u and v and multiplies by the q16 coefficients
// depends on y2r_pkg
`default_nettype none

module y2r_chroma (
	input  wire logic [y2r_pkg::PIX_W-1:0] chroma_blue,
	input  wire logic [y2r_pkg::PIX_W-1:0] chroma_red,
	output y2r_pkg::chroma_prod_t          prod
);
	import y2r_pkg::*;

	logic signed [PIX_W:0]  du;
	logic signed [PIX_W:0]  dv;
	logic signed [COEF_W:0] k_vr;
	logic signed [COEF_W:0] k_vg;
	logic signed [COEF_W:0] k_ug;
	logic signed [COEF_W:0] k_ub;

	assign du = $signed({1'b0, chroma_blue}) - $signed(CHROMA_ZERO);
	assign dv = $signed({1'b0, chroma_red}) - $signed(CHROMA_ZERO);

	assign k_vr = $signed({1'b0, COEF_V_TO_R});
	assign k_vg = $signed({1'b0, COEF_V_TO_G});
	assign k_ug = $signed({1'b0, COEF_U_TO_G});
	assign k_ub = $signed({1'b0, COEF_U_TO_B});

	assign prod.vr = k_vr * dv;
	assign prod.vg = k_vg * dv;
	assign prod.ug = k_ug * du;
	assign prod.ub = k_ub * du;

endmodule

`default_nettype wire

// ===== hw/rtl/y2r_lane.sv =====
// one pixel lane: adds luma to the chroma products, clamps and scales to 0..219
// depends on y2r_pkg
`default_nettype none

module y2r_lane (
	input  wire logic [y2r_pkg::PIX_W-1:0] luma,
	input  y2r_pkg::chroma_prod_t          prod,
	output y2r_pkg::rgb_t                  pix
);
	import y2r_pkg::*;

	function automatic logic signed [SUM_W-1:0] sext(input logic signed [PROD_W-1:0] p);
		return $signed({{(SUM_W-PROD_W){p[PROD_W-1]}}, p});
	endfunction

	// negative sums go to zero, large ones saturate, then c*220>>8
	function automatic logic [PIX_W-1:0] chan_finish(input logic signed [SUM_W-1:0] sum);
		logic [SUM_W-FRAC_W-2:0] whole;
		logic [PIX_W-1:0]        clamped;
		logic [2*PIX_W-1:0]      scaled;
		whole = sum[SUM_W-2:FRAC_W];
		if (sum[SUM_W-1]) begin
			clamped = '0;
		end else if (whole > (SUM_W-FRAC_W-1)'(CHAN_MAX)) begin
			clamped = CHAN_MAX;
		end else begin
			clamped = whole[PIX_W-1:0];
		end
		scaled = (2*PIX_W)'(clamped) * (2*PIX_W)'(SCALE_NUM);
		return scaled[SCALE_SHIFT+PIX_W-1:SCALE_SHIFT];
	endfunction

	logic signed [SUM_W-1:0] base;
	logic signed [SUM_W-1:0] sum_r;
	logic signed [SUM_W-1:0] sum_g;
	logic signed [SUM_W-1:0] sum_b;

	assign base  = $signed({{(SUM_W-PIX_W-FRAC_W){1'b0}}, luma, {FRAC_W{1'b0}}});
	assign sum_r = base + sext(prod.vr);
	assign sum_g = base - sext(prod.vg) - sext(prod.ug);
	assign sum_b = base + sext(prod.ub);

	assign pix.red   = chan_finish(sum_r);
	assign pix.green = chan_finish(sum_g);
	assign pix.blue  = chan_finish(sum_b);

endmodule

`default_nettype wire

// ===== hw/rtl/yuyv422_to_rgb888_converter.sv =====
// yuyv 4:2:2 macropixel to rgb888 pixel pair converter, top level
// depends on y2r_pkg, y2r_ifs, y2r_chroma, y2r_lane and the assertion macro header
//
// usage:
//   yuyv carries one macropixel per beat (luma_first, chroma_blue, luma_second,
//   chroma_red, frame_end_in); rgb carries the two converted pixels of that
//   macropixel plus frame_end_out. a beat moves when valid and ready are high.
//   an accepted beat is registered in stage one (chroma multipliers), then in
//   the output register (the two pixel lanes). throughput: one macropixel per
//   cycle unless rgb stalls, set by this two-stage pipeline.
//   the shared chroma products feed both lanes; the output register merges
//   the two lane results with the frame end flag.
//   reset clears both stage valid bits; nothing else needs clearing.
//   when the receiver stalls, the output register holds its beat, stage one
//   still takes one more beat, and yuyv.ready drops once both stages are full.
//   the ready path runs combinationally from rgb.ready to yuyv.ready.
`default_nettype none
`include "yuyv422_to_rgb888_converter_defines.svh"

module yuyv422_to_rgb888_converter (
	input  wire logic clk,
	input  wire logic arst_n,
	yuyv_if.sink      yuyv,
	rgb_if.source     rgb
);
	import y2r_pkg::*;

	logic                 valid_s1;
	logic                 valid_s2;
	logic                 s1_ready;
	logic                 s2_ready;
	chroma_prod_t         prod;
	chroma_prod_t         prod_s1;
	logic [PIX_W-1:0]     luma_first_s1;
	logic [PIX_W-1:0]     luma_second_s1;
	logic                 frame_end_s1;
	rgb_t                 lane_first;
	rgb_t                 lane_second;
	rgb_t                 pix_first_s2;
	rgb_t                 pix_second_s2;
	logic                 frame_end_s2;

	assign s2_ready   = !valid_s2 || rgb.ready;
	assign s1_ready   = !valid_s1 || s2_ready;
	assign yuyv.ready = s1_ready;

	y2r_chroma u_chroma (
		.chroma_blue (yuyv.chroma_blue),
		.chroma_red  (yuyv.chroma_red),
		.prod        (prod)
	);

	y2r_lane u_lane_first (
		.luma (luma_first_s1),
		.prod (prod_s1),
		.pix  (lane_first)
	);

	y2r_lane u_lane_second (
		.luma (luma_second_s1),
		.prod (prod_s1),
		.pix  (lane_second)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= yuyv.valid;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && yuyv.valid) begin
			prod_s1        <= prod;
			luma_first_s1  <= yuyv.luma_first;
			luma_second_s1 <= yuyv.luma_second;
			frame_end_s1   <= yuyv.frame_end_in;
		end
		// merge the two lanes into the output register
		if (s2_ready && valid_s1) begin
			pix_first_s2  <= lane_first;
			pix_second_s2 <= lane_second;
			frame_end_s2  <= frame_end_s1;
		end
	end

	assign rgb.valid         = valid_s2;
	assign rgb.red_first     = pix_first_s2.red;
	assign rgb.green_first   = pix_first_s2.green;
	assign rgb.blue_first    = pix_first_s2.blue;
	assign rgb.red_second    = pix_second_s2.red;
	assign rgb.green_second  = pix_second_s2.green;
	assign rgb.blue_second   = pix_second_s2.blue;
	assign rgb.frame_end_out = frame_end_s2;

	`Y2R_ASSERT_NXT(a_accept_fills_s1, clk, arst_n, yuyv.valid && yuyv.ready, valid_s1)
	`Y2R_ASSERT_NXT(a_s1_moves_to_out, clk, arst_n, valid_s1 && s2_ready, rgb.valid)
	`Y2R_ASSERT_IMP(a_full_blocks_input, clk, arst_n,
		valid_s1 && valid_s2 && !rgb.ready, !yuyv.ready)
	`Y2R_ASSERT_IMP(a_out_in_range, clk, arst_n, rgb.valid,
		(rgb.red_first <= SCALE_MAX) && (rgb.green_first <= SCALE_MAX) &&
		(rgb.blue_first <= SCALE_MAX) && (rgb.red_second <= SCALE_MAX) &&
		(rgb.green_second <= SCALE_MAX) && (rgb.blue_second <= SCALE_MAX))

endmodule

`default_nettype wire
